// ===== rtl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the cell to 24-bit colour terminal encoder.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH      = 2'd0,
    CFG_IMAGE_HEIGHT     = 2'd1,
    CFG_TERMINAL_COLUMNS = 2'd2,
    CFG_TERMINAL_ROWS    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [15:0] terminal_columns;
    logic [15:0] terminal_rows;
  } crt_cfg_t;

  // byte constants
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_THREE   = 8'h33;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_EIGHT   = 8'h38;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // segments of one cell's byte run, in emission order
  typedef enum logic [2:0] {
    SEG_NL  = 3'd0,
    SEG_FG  = 3'd1,
    SEG_BG  = 3'd2,
    SEG_CHR = 3'd3,
    SEG_RST = 3'd4
  } seg_t;

  localparam int NUM_SEG = 5;
  localparam int IDX_W   = 5;

  localparam logic [IDX_W-1:0] COLOR_LAST = 5'd18;
  localparam logic [IDX_W-1:0] RST_LAST   = 5'd2;

  // one cell's work: which segments run, and their payload
  typedef struct packed {
    logic [NUM_SEG-1:0] en;
    logic [7:0]         char_byte;
    logic [23:0]        fore;
    logic [23:0]        back;
  } crt_run_t;

endpackage

// ===== rtl/crt_decode.sv =====
// ----------------------------------------------------------------------------
// crt_decode
// Tracks column, row and last emitted colours and decides, per cell, which
// segments of the byte run are emitted.
// ----------------------------------------------------------------------------
module crt_decode import crt_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  crt_cfg_t   cfg,
  input  logic       fire,
  input  logic [7:0] cell_char,
  input  logic [7:0] fore_red,
  input  logic [7:0] fore_green,
  input  logic [7:0] fore_blue,
  input  logic [7:0] back_red,
  input  logic [7:0] back_green,
  input  logic [7:0] back_blue,
  output crt_run_t   run,
  output logic       run_any
);

  localparam int CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W = ((DIM_W > 16) ? DIM_W : 16) + 1;

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [23:0]      last_fore_color, last_fore_color_next;
  logic [23:0]      last_back_color, last_back_color_next;

  logic [23:0]      fore, back;
  logic [CMP_W-1:0] w, h, tc, tr, col, row, col_inc, row_inc, min_wc, last_col;
  logic             row_vis, col0, mid_vis;
  logic             en_nl, en_fg, en_bg, en_chr, en_rst;
  logic [7:0]       char_byte;

  always_comb begin
    fore = {fore_red, fore_green, fore_blue};
    back = {back_red, back_green, back_blue};

    // clamp frame size to 1..MAX_DIMENSION
    w = CMP_W'(cfg.image_width);
    if (w == '0) begin
      w = CMP_W'(1);
    end else if (w > CMP_W'(MAX_DIMENSION)) begin
      w = CMP_W'(MAX_DIMENSION);
    end
    h = CMP_W'(cfg.image_height);
    if (h == '0) begin
      h = CMP_W'(1);
    end else if (h > CMP_W'(MAX_DIMENSION)) begin
      h = CMP_W'(MAX_DIMENSION);
    end

    tc      = CMP_W'(cfg.terminal_columns);
    tr      = CMP_W'(cfg.terminal_rows);
    col     = CMP_W'(column_count);
    row     = CMP_W'(row_count);
    col_inc = col + CMP_W'(1);
    row_inc = row + CMP_W'(1);

    min_wc   = (w < tc) ? w : tc;
    last_col = (min_wc == '0) ? '0 : min_wc - CMP_W'(1);

    row_vis = (row < h) && (row < tr);
    col0    = (col == '0);
    mid_vis = !col0 && (col < w) && (col < tc);

    en_nl  = row_vis && col0 && (row != '0);
    en_fg  = row_vis && (col0 || (mid_vis && (cell_char != CH_SPACE) &&
                                  (fore != last_fore_color)));
    en_bg  = row_vis && (col0 || (mid_vis && (back != last_back_color)));
    en_chr = row_vis && (col0 || mid_vis);
    en_rst = row_vis && (col == last_col);

    if (cell_char inside {[CH_SPACE:CH_TILDE]}) begin
      char_byte = cell_char;
    end else begin
      char_byte = CH_QUERY;
    end

    run.en        = {en_rst, en_chr, en_bg, en_fg, en_nl};
    run.char_byte = char_byte;
    run.fore      = fore;
    run.back      = back;
    run_any       = |run.en;

    // counters wrap at the end of a row and of the frame
    if (col_inc >= w) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      column_count_next = col_inc[CNT_W-1:0];
      row_count_next    = row_count;
    end

    last_fore_color_next = en_fg ? fore : last_fore_color;
    last_back_color_next = en_bg ? back : last_back_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      last_fore_color <= '0;
      last_back_color <= '0;
    end else if (fire) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      last_fore_color <= last_fore_color_next;
      last_back_color <= last_back_color_next;
    end
  end

endmodule

// ===== rtl/crt_emit.sv =====
// ----------------------------------------------------------------------------
// crt_emit
// Byte sequencer: holds one cell's run and steps through its segments,
// giving one byte per cycle while the output buffer has room.
// ----------------------------------------------------------------------------
module crt_emit import crt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  crt_run_t   run_in,
  output logic       load_ok,
  input  logic       room,
  output logic       push,
  output logic [7:0] push_byte,
  output logic       push_last
);

  crt_run_t         run;
  logic             run_valid;
  seg_t             seg, seg_next, seg_first;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] seg_last_idx;
  logic             seg_done, has_next, adv;
  logic [7:0]       chan;
  logic [23:0]      digits;
  logic [23:0]      rgb;
  logic [7:0]       kind;

  function automatic logic [23:0] dec3(input logic [7:0] v);
    logic [1:0]  hun;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  ten;
    logic [3:0]  one;
    if (v >= 8'd200) begin
      hun = 2'd2;
      rem = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      hun = 2'd1;
      rem = 7'(v - 8'd100);
    end else begin
      hun = 2'd0;
      rem = v[6:0];
    end
    // rem below 100: times 205 over 2048 gives the tens digit
    prod = 15'(rem) * 15'd205;
    ten  = prod[14:11];
    one  = 4'(rem - 7'(ten) * 7'd10);
    return {6'b001100, hun, 4'h3, ten, 4'h3, one};
  endfunction

  always_comb begin
    // first enabled segment of the incoming run
    seg_first = SEG_RST;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (run_in.en[i]) begin
        seg_first = seg_t'(i[2:0]);
      end
    end

    // next enabled segment after the current one
    seg_next = SEG_RST;
    has_next = 1'b0;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (run.en[i] && (3'(i) > seg)) begin
        seg_next = seg_t'(i[2:0]);
        has_next = 1'b1;
      end
    end

    case (seg)
      SEG_FG, SEG_BG: seg_last_idx = COLOR_LAST;
      SEG_RST:        seg_last_idx = RST_LAST;
      default:        seg_last_idx = '0;
    endcase

    seg_done  = (idx == seg_last_idx);
    adv       = run_valid && room;
    push      = adv;
    push_last = seg_done && !has_next;
    load_ok   = !run_valid || (adv && push_last);
  end

  always_comb begin
    rgb  = (seg == SEG_BG) ? run.back : run.fore;
    kind = (seg == SEG_BG) ? CH_FOUR : CH_THREE;
    if (idx < 5'd11) begin
      chan = rgb[23:16];
    end else if (idx < 5'd15) begin
      chan = rgb[15:8];
    end else begin
      chan = rgb[7:0];
    end
    digits = dec3(chan);

    push_byte = CH_ESC;
    case (seg)
      SEG_NL:  push_byte = CH_NEWLINE;
      SEG_CHR: push_byte = run.char_byte;
      SEG_RST: begin
        case (idx)
          5'd0:    push_byte = CH_ESC;
          5'd1:    push_byte = CH_LBRACK;
          default: push_byte = CH_M;
        endcase
      end
      SEG_FG, SEG_BG: begin
        case (idx)
          5'd0:                   push_byte = CH_ESC;
          5'd1:                   push_byte = CH_LBRACK;
          5'd2:                   push_byte = kind;
          5'd3:                   push_byte = CH_EIGHT;
          5'd5:                   push_byte = CH_TWO;
          5'd4, 5'd6, 5'd10, 5'd14: push_byte = CH_SEMI;
          5'd7, 5'd11, 5'd15:     push_byte = digits[23:16];
          5'd8, 5'd12, 5'd16:     push_byte = digits[15:8];
          5'd9, 5'd13, 5'd17:     push_byte = digits[7:0];
          default:                push_byte = CH_M;
        endcase
      end
      default: push_byte = CH_ESC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      seg       <= SEG_NL;
      idx       <= '0;
    end else if (load_ok) begin
      run_valid <= load;
      seg       <= seg_first;
      idx       <= '0;
    end else if (adv) begin
      if (seg_done) begin
        seg <= seg_next;
        idx <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && load) begin
      run <= run_in;
    end
  end

endmodule

// ===== rtl/crt_skid.sv =====
// ----------------------------------------------------------------------------
// crt_skid
// Two-entry output buffer; room is a registered flag so the downstream ready
// never reaches the cell input.
// ----------------------------------------------------------------------------
module crt_skid import crt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_byte,
  input  logic       push_last,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic       main_valid, spare_valid;
  logic [7:0] spare_byte;
  logic       spare_last;
  logic       pop;

  assign room      = !spare_valid;
  assign out_valid = main_valid;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      main_valid  <= spare_valid || push;
      spare_valid <= 1'b0;
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (spare_valid) begin
        out_byte <= spare_byte;
        run_last <= spare_last;
      end else begin
        out_byte <= push_byte;
        run_last <= push_last;
      end
    end else if (push) begin
      spare_byte <= push_byte;
      spare_last <= push_last;
    end
  end

endmodule

// ===== rtl/cell_to_ansi_truecolor_stream.sv =====
// ----------------------------------------------------------------------------
// cell_to_ansi_truecolor_stream
// Turns frame-buffer cells into a 24-bit colour terminal byte stream.
// ----------------------------------------------------------------------------
// A cell's bytes leave one per cycle while the output buffer has room, so a
// cell that gives n bytes holds the cell input until its last byte is pushed
// (1 byte for a plain character, up to 43 for a row start with newline, both
// colour sequences and the trailing ESC[m); a hidden cell gives no bytes and
// does not load the byte sequencer. Output bytes pass through a two-entry
// buffer, so a cell is taken while finished bytes still wait downstream.
// Configuration writes are always ready and take effect on the next cell.
module cell_to_ansi_truecolor_stream import crt_pkg::*; #(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            cell_char,
  input  logic [7:0]            fore_red,
  input  logic [7:0]            fore_green,
  input  logic [7:0]            fore_blue,
  input  logic [7:0]            back_red,
  input  logic [7:0]            back_green,
  input  logic [7:0]            back_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  run_last
);

  crt_cfg_t   cfg;
  crt_run_t   run;
  logic       run_any;
  logic       fire;
  logic       room, push, push_last;
  logic [7:0] push_byte;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width      <= 13'd80;
      cfg.image_height     <= 13'd24;
      cfg.terminal_columns <= 16'd80;
      cfg.terminal_rows    <= 16'd24;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:      cfg.image_width      <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT:     cfg.image_height     <= cfg_data[12:0];
        CFG_TERMINAL_COLUMNS: cfg.terminal_columns <= cfg_data;
        CFG_TERMINAL_ROWS:    cfg.terminal_rows    <= cfg_data;
        default:              cfg.terminal_rows    <= cfg.terminal_rows;
      endcase
    end
  end

  crt_decode #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (fire),
    .cell_char (cell_char),
    .fore_red  (fore_red),
    .fore_green(fore_green),
    .fore_blue (fore_blue),
    .back_red  (back_red),
    .back_green(back_green),
    .back_blue (back_blue),
    .run       (run),
    .run_any   (run_any)
  );

  crt_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && run_any),
    .run_in   (run),
    .load_ok  (in_ready),
    .room     (room),
    .push     (push),
    .push_byte(push_byte),
    .push_last(push_last)
  );

  crt_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_byte(push_byte),
    .push_last(push_last),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_last (run_last)
  );

endmodule
